>>> rtl/core/linear_state_observer_step_defines.svh
// Assertion macros for the observer core
`ifndef LINEAR_STATE_OBSERVER_STEP_DEFINES_SVH
`define LINEAR_STATE_OBSERVER_STEP_DEFINES_SVH
// assert that an antecedent implies a consequent in the same cycle
`define LSO_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lso check failed");
// assert that an antecedent implies a consequent in the next cycle
`define LSO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lso check failed");
`endif

>>> rtl/core/lso_pkg.sv
// Package for the observer core: sizes, item types, codes and arithmetic helpers
package lso_pkg;
  localparam int STATE_SIZE  = 4;
  localparam int INPUT_SIZE  = 2;
  localparam int OUTPUT_SIZE = 2;

  localparam int X_IDX_W = (STATE_SIZE > 1) ? $clog2(STATE_SIZE) : 1;
  localparam int U_IDX_W = (INPUT_SIZE > 1) ? $clog2(INPUT_SIZE) : 1;
  localparam int Y_IDX_W = (OUTPUT_SIZE > 1) ? $clog2(OUTPUT_SIZE) : 1;
  localparam int A_IDX_W = (STATE_SIZE*STATE_SIZE > 1) ? $clog2(STATE_SIZE*STATE_SIZE) : 1;
  localparam int B_IDX_W = (STATE_SIZE*INPUT_SIZE > 1) ? $clog2(STATE_SIZE*INPUT_SIZE) : 1;
  localparam int C_IDX_W = (OUTPUT_SIZE*STATE_SIZE > 1) ? $clog2(OUTPUT_SIZE*STATE_SIZE) : 1;
  localparam int L_IDX_W = (STATE_SIZE*OUTPUT_SIZE > 1) ? $clog2(STATE_SIZE*OUTPUT_SIZE) : 1;

  localparam logic [1:0] ACT_COEF = 2'd0;
  localparam logic [1:0] ACT_SAMP = 2'd1;
  localparam logic [1:0] ACT_STEP = 2'd2;

  localparam logic [1:0] MSEL_A = 2'd0;
  localparam logic [1:0] MSEL_B = 2'd1;
  localparam logic [1:0] MSEL_C = 2'd2;
  localparam logic [1:0] MSEL_L = 2'd3;

  localparam logic VSEL_U = 1'b0;

  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         matrix_select;
    logic               vector_select;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] data_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         element_index;
    logic signed [31:0] estimate_value;
    logic               last_element;
  } out_item_t;

  function automatic logic signed [31:0] clamp33(input logic signed [32:0] v);
    logic signed [31:0] r;
    begin
      if (v > 33'sd2147483647) r = 32'sh7fffffff;
      else if (v < -33'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
    end
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return clamp33({a[31], a} + {b[31], b});
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    return clamp33({a[31], a} - {b[31], b});
  endfunction

  function automatic logic signed [31:0] q_sat(input logic signed [63:0] p);
    logic signed [47:0] q;
    logic signed [31:0] r;
    begin
      q = p[63:16];
      if (q > 48'sd2147483647) r = 32'sh7fffffff;
      else if (q < -48'sd2147483648) r = 32'sh80000000;
      else r = q[31:0];
      return r;
    end
  endfunction
endpackage

>>> rtl/core/linear_state_observer_step.sv
// Top level of the discrete Luenberger observer core
// Write items are stored by the back end as they leave the queue; a step that reaches an idle core
// runs all its dot products on the single shared multiply-accumulate unit. A two-entry
// command queue takes items while a step runs; busy is high when it is full. Results come
// out one per cycle, STATE_SIZE in a row, and cannot be stalled.
module linear_state_observer_step import lso_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  in_item_t  in_item,
  output logic      busy,
  output logic      result,
  output out_item_t out_item
);
  logic     q_pop, q_valid;
  in_item_t q_head;

  lso_front u_front (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item), .busy(busy),
    .q_pop(q_pop), .q_valid(q_valid), .q_head(q_head)
  );

  lso_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop),
    .result(result), .out_item(out_item)
  );
endmodule

>>> rtl/core/lso_front.sv
// Front end: accept items, drop invalid ones, push to the command queue
module lso_front import lso_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  in_item_t in_item,
  output logic     busy,
  input  logic     q_pop,
  output logic     q_valid,
  output in_item_t q_head
);
  in_item_t              mem [QDEPTH];
  logic [$clog2(QDEPTH)-1:0] wptr, rptr;
  logic [$clog2(QDEPTH):0]   count;
  logic keep, push;

  always_comb begin
    case (in_item.action)
      ACT_COEF, ACT_SAMP, ACT_STEP: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign busy    = (count == ($clog2(QDEPTH)+1)'(QDEPTH));
  assign push    = start && !busy && keep;
  assign q_valid = (count != '0);
  assign q_head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (q_pop ? 1'b1 : 1'b0);
    end
  end

`include "linear_state_observer_step_defines.svh"
  `LSO_ASSERT_SAME(a_pop_nonempty, q_pop, q_valid)
  `LSO_ASSERT_SAME(a_count_bound, 1'b1, count <= ($clog2(QDEPTH)+1)'(QDEPTH))
  `LSO_ASSERT_NEXT(a_push_fills, push && !q_pop, count == $past(count) + 1'b1)
endmodule

>>> rtl/core/lso_back.sv
// Back end: store writes and run the observer step on one shared MAC unit
module lso_back import lso_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  in_item_t  q_head,
  output logic      q_pop,
  output logic      result,
  output out_item_t out_item
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CX   = 5'b00010,
    S_ROW  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  typedef enum logic [2:0] {
    P_A = 3'b001, P_B = 3'b010, P_L = 3'b100
  } phase_t;

  logic signed [31:0] ma [STATE_SIZE*STATE_SIZE];
  logic signed [31:0] mb [STATE_SIZE*INPUT_SIZE];
  logic signed [31:0] mc [OUTPUT_SIZE*STATE_SIZE];
  logic signed [31:0] ml [STATE_SIZE*OUTPUT_SIZE];
  logic signed [31:0] xs [STATE_SIZE];
  logic signed [31:0] xn [STATE_SIZE];
  logic signed [31:0] uv [INPUT_SIZE];
  logic signed [31:0] yv [OUTPUT_SIZE];
  logic signed [31:0] err [OUTPUT_SIZE];

  state_t state, state_next;
  phase_t phase;
  logic [2:0] i, j;
  logic signed [31:0] acc, ax, bu;
  logic signed [31:0] opa, opb;
  logic signed [63:0] prod;
  logic               pvalid, plast;
  logic signed [31:0] term, acc_sum;
  logic [2:0] jlim;

  always_comb begin
    opa = '0;
    opb = '0;
    jlim = 3'(STATE_SIZE - 1);
    case (state)
      S_CX: begin
        opa = mc[C_IDX_W'(int'(i) * STATE_SIZE + int'(j))];
        opb = xs[X_IDX_W'(j)];
      end
      S_ROW: begin
        case (phase)
          P_A: begin
            opa = ma[A_IDX_W'(int'(i) * STATE_SIZE + int'(j))];
            opb = xs[X_IDX_W'(j)];
          end
          P_B: begin
            opa = mb[B_IDX_W'(int'(i) * INPUT_SIZE + int'(j))];
            opb = uv[U_IDX_W'(j)];
            jlim = 3'(INPUT_SIZE - 1);
          end
          P_L: begin
            opa = ml[L_IDX_W'(int'(i) * OUTPUT_SIZE + int'(j))];
            opb = err[Y_IDX_W'(j)];
            jlim = 3'(OUTPUT_SIZE - 1);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign term    = q_sat(prod);
  assign acc_sum = sat_add(acc, term);
  assign q_pop   = (state == S_IDLE) && q_valid && !pvalid;

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STATE_SIZE*STATE_SIZE; k++) ma[k] <= '0;
      for (int k = 0; k < STATE_SIZE*INPUT_SIZE; k++) mb[k] <= '0;
      for (int k = 0; k < OUTPUT_SIZE*STATE_SIZE; k++) mc[k] <= '0;
      for (int k = 0; k < STATE_SIZE*OUTPUT_SIZE; k++) ml[k] <= '0;
      for (int k = 0; k < STATE_SIZE; k++) xs[k] <= '0;
      for (int k = 0; k < INPUT_SIZE; k++) uv[k] <= '0;
      for (int k = 0; k < OUTPUT_SIZE; k++) yv[k] <= '0;
    end else begin
      if (q_pop && q_head.action == ACT_COEF) begin
        case (q_head.matrix_select)
          MSEL_A: if (int'(q_head.row_index) < STATE_SIZE && int'(q_head.col_index) < STATE_SIZE)
            ma[A_IDX_W'(int'(q_head.row_index)*STATE_SIZE + int'(q_head.col_index))]
              <= q_head.data_value;
          MSEL_B: if (int'(q_head.row_index) < STATE_SIZE && int'(q_head.col_index) < INPUT_SIZE)
            mb[B_IDX_W'(int'(q_head.row_index)*INPUT_SIZE + int'(q_head.col_index))]
              <= q_head.data_value;
          MSEL_C: if (int'(q_head.row_index) < OUTPUT_SIZE && int'(q_head.col_index) < STATE_SIZE)
            mc[C_IDX_W'(int'(q_head.row_index)*STATE_SIZE + int'(q_head.col_index))]
              <= q_head.data_value;
          MSEL_L: if (int'(q_head.row_index) < STATE_SIZE && int'(q_head.col_index) < OUTPUT_SIZE)
            ml[L_IDX_W'(int'(q_head.row_index)*OUTPUT_SIZE + int'(q_head.col_index))]
              <= q_head.data_value;
          default: ;
        endcase
      end
      if (q_pop && q_head.action == ACT_SAMP) begin
        if (q_head.vector_select == VSEL_U) begin
          if (int'(q_head.row_index) < INPUT_SIZE)
            uv[U_IDX_W'(q_head.row_index)] <= q_head.data_value;
        end else begin
          if (int'(q_head.row_index) < OUTPUT_SIZE)
            yv[Y_IDX_W'(q_head.row_index)] <= q_head.data_value;
        end
      end
      if (state == S_OUT && int'(i) == STATE_SIZE - 1) begin
        for (int k = 0; k < STATE_SIZE; k++) xs[k] <= xn[k];
      end
    end
  end

  // sequencer: issue one product a cycle, accumulate it in the following cycle
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (q_pop && q_head.action == ACT_STEP) state_next = S_CX;
      S_CX:   if (j == 3'(STATE_SIZE - 1) && int'(i) == OUTPUT_SIZE - 1) state_next = S_ROW;
      S_ROW:  if (phase == P_L && j == jlim && int'(i) == STATE_SIZE - 1) state_next = S_FIN;
      S_FIN:  state_next = S_OUT;
      S_OUT:  if (int'(i) == STATE_SIZE - 1) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      phase  <= P_A;
      i      <= '0;
      j      <= '0;
      pvalid <= 1'b0;
      plast  <= 1'b0;
      acc    <= '0;
      result <= 1'b0;
    end else begin
      state  <= state_next;
      result <= 1'b0;
      pvalid <= (state == S_CX) || (state == S_ROW);
      plast  <= ((state == S_CX) || (state == S_ROW)) && j == jlim;
      if (pvalid) begin
        acc <= plast ? '0 : acc_sum;
      end
      case (state)
        S_IDLE: begin
          i <= '0;
          j <= '0;
          phase <= P_A;
          acc <= '0;
        end
        S_CX, S_ROW: begin
          if (j == jlim) begin
            j <= '0;
            if (state == S_CX) begin
              i <= (int'(i) == OUTPUT_SIZE - 1) ? '0 : i + 1'b1;
            end else begin
              case (phase)
                P_A: phase <= P_B;
                P_B: phase <= P_L;
                default: begin
                  phase <= P_A;
                  i <= (int'(i) == STATE_SIZE - 1) ? '0 : i + 1'b1;
                end
              endcase
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_FIN: i <= '0;
        S_OUT: begin
          result <= 1'b1;
          out_item.element_index  <= i;
          out_item.estimate_value <= xn[X_IDX_W'(i)];
          out_item.last_element   <= (int'(i) == STATE_SIZE - 1);
          i <= i + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // track which dot product finishes as products drain
  phase_t     dphase;
  logic       dcx;
  logic [2:0] di;
  always_ff @(posedge clk) begin
    dphase <= phase;
    dcx    <= (state == S_CX);
    di     <= i;
    if (pvalid && plast) begin
      if (dcx) err[Y_IDX_W'(di)] <= sat_sub(yv[Y_IDX_W'(di)], acc_sum);
      else begin
        case (dphase)
          P_A: ax <= acc_sum;
          P_B: bu <= acc_sum;
          P_L: xn[X_IDX_W'(di)] <= sat_add(sat_add(ax, bu), acc_sum);
          default: ;
        endcase
      end
    end
  end

`include "linear_state_observer_step_defines.svh"
  `LSO_ASSERT_SAME(a_no_pop_busy, q_pop, state == S_IDLE)
  `LSO_ASSERT_SAME(a_result_idx, result && out_item.last_element,
                   int'(out_item.element_index) == STATE_SIZE - 1)
  `LSO_ASSERT_NEXT(a_out_strobe, state == S_OUT, result)
endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the Luenberger observer core: table-driven and random items
module tb;
  import lso_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  in_item_t in_item = '0;
  logic busy;
  logic result;
  out_item_t out_item;

  linear_state_observer_step uut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .result(result), .out_item(out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic signed [31:0] coef_a [STATE_SIZE*STATE_SIZE];
  logic signed [31:0] coef_b [STATE_SIZE*INPUT_SIZE];
  logic signed [31:0] coef_c [OUTPUT_SIZE*STATE_SIZE];
  logic signed [31:0] coef_l [STATE_SIZE*OUTPUT_SIZE];
  logic signed [31:0] est_x [STATE_SIZE];
  logic signed [31:0] ctl_u [INPUT_SIZE];
  logic signed [31:0] meas_y [OUTPUT_SIZE];

  out_item_t estimate_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  function automatic logic signed [31:0] clip(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [65:0] p;
    p = 66'(a) * 66'(b);
    return clip(p >>> 16);
  endfunction

  function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    return clip(66'(a) + 66'(b));
  endfunction

  task automatic predict_item(input in_item_t it);
    logic signed [31:0] err [OUTPUT_SIZE];
    logic signed [31:0] nxt [STATE_SIZE];
    logic signed [31:0] ax, bu, lr, acc;
    int r, c;
    out_item_t o;
    r = it.row_index;
    c = it.col_index;
    if (it.action == ACT_COEF) begin
      case (it.matrix_select)
        MSEL_A: if (r < STATE_SIZE && c < STATE_SIZE) coef_a[r*STATE_SIZE+c] = it.data_value;
        MSEL_B: if (r < STATE_SIZE && c < INPUT_SIZE) coef_b[r*INPUT_SIZE+c] = it.data_value;
        MSEL_C: if (r < OUTPUT_SIZE && c < STATE_SIZE) coef_c[r*STATE_SIZE+c] = it.data_value;
        default: if (r < STATE_SIZE && c < OUTPUT_SIZE) coef_l[r*OUTPUT_SIZE+c] = it.data_value;
      endcase
    end else if (it.action == ACT_SAMP) begin
      if (it.vector_select == VSEL_U) begin
        if (r < INPUT_SIZE) ctl_u[r] = it.data_value;
      end else if (r < OUTPUT_SIZE) begin
        meas_y[r] = it.data_value;
      end
    end else if (it.action == ACT_STEP) begin
      for (int i = 0; i < OUTPUT_SIZE; i++) begin
        acc = 0;
        for (int j = 0; j < STATE_SIZE; j++)
          acc = sadd(acc, qmul(coef_c[i*STATE_SIZE+j], est_x[j]));
        err[i] = clip(66'(meas_y[i]) - 66'(acc));
      end
      for (int i = 0; i < STATE_SIZE; i++) begin
        ax = 0; bu = 0; lr = 0;
        for (int j = 0; j < STATE_SIZE; j++) ax = sadd(ax, qmul(coef_a[i*STATE_SIZE+j], est_x[j]));
        for (int j = 0; j < INPUT_SIZE; j++) bu = sadd(bu, qmul(coef_b[i*INPUT_SIZE+j], ctl_u[j]));
        for (int j = 0; j < OUTPUT_SIZE; j++) lr = sadd(lr, qmul(coef_l[i*OUTPUT_SIZE+j], err[j]));
        nxt[i] = sadd(sadd(ax, bu), lr);
      end
      for (int i = 0; i < STATE_SIZE; i++) begin
        est_x[i] = nxt[i];
        o.element_index = 3'(i);
        o.estimate_value = nxt[i];
        o.last_element = (i == STATE_SIZE - 1);
        estimate_q.push_back(o);
      end
    end
  endtask

  // Check estimates against the prediction
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && result) begin
      if (estimate_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected estimate %p", out_item);
      end else begin
        e = estimate_q.pop_front();
        if (out_item !== e) begin
          mismatches++;
          if (mismatches <= 10) $display("estimate mismatch: expected %p actual %p", e, out_item);
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (rst || result || (start && !busy)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [1:0] act, input logic [1:0] ms,
                                         input logic vs, input logic [2:0] r,
                                         input logic [2:0] c, input logic [31:0] d);
    in_item_t it;
    it.action = act; it.matrix_select = ms; it.vector_select = vs;
    it.row_index = r; it.col_index = c; it.data_value = d;
    return it;
  endfunction

  function automatic int gap_len();
    int n;
    n = $urandom_range(0, 9);
    if (n < 5) n = 0;
    else if (n < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    return n;
  endfunction

  // Present one item and hold it until the transfer
  task automatic send_item(input in_item_t it, input bit gap);
    int n;
    n = gap ? gap_len() : 0;
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_item <= it;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(it);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 262143)) - 131072);
      3: return 32'($signed($urandom_range(0, 131071)) - 65536) << 4;
      default: return $urandom;
    endcase
  endfunction

  in_item_t stim_table [$];
  in_item_t it;

  initial begin
    foreach (coef_a[i]) coef_a[i] = 0;
    foreach (coef_b[i]) coef_b[i] = 0;
    foreach (coef_c[i]) coef_c[i] = 0;
    foreach (coef_l[i]) coef_l[i] = 0;
    foreach (est_x[i]) est_x[i] = 0;
    foreach (ctl_u[i]) ctl_u[i] = 0;
    foreach (meas_y[i]) meas_y[i] = 0;

    stim_table = '{
      make_item(ACT_STEP, MSEL_A, VSEL_U, 3'd0, 3'd0, 32'h0),
      make_item(ACT_COEF, MSEL_A, VSEL_U, 3'd0, 3'd0, 32'h7fffffff),
      make_item(ACT_COEF, MSEL_A, VSEL_U, 3'd3, 3'd3, 32'h80000000),
      make_item(ACT_COEF, MSEL_A, VSEL_U, 3'd7, 3'd0, 32'h11111111),
      make_item(ACT_COEF, MSEL_B, VSEL_U, 3'd0, 3'd0, 32'h00010000),
      make_item(ACT_COEF, MSEL_B, VSEL_U, 3'd3, 3'd1, 32'hffff0000),
      make_item(ACT_COEF, MSEL_B, VSEL_U, 3'd0, 3'd2, 32'h22222222),
      make_item(ACT_COEF, MSEL_C, VSEL_U, 3'd1, 3'd3, 32'h00020000),
      make_item(ACT_COEF, MSEL_C, VSEL_U, 3'd2, 3'd0, 32'h33333333),
      make_item(ACT_COEF, MSEL_L, VSEL_U, 3'd3, 3'd1, 32'h00008000),
      make_item(ACT_COEF, MSEL_L, VSEL_U, 3'd4, 3'd7, 32'h44444444),
      make_item(ACT_SAMP, MSEL_A, VSEL_U, 3'd0, 3'd0, 32'h7fffffff),
      make_item(ACT_SAMP, MSEL_A, VSEL_U, 3'd1, 3'd7, 32'h80000000),
      make_item(ACT_SAMP, MSEL_A, VSEL_U, 3'd2, 3'd0, 32'h55555555),
      make_item(ACT_SAMP, MSEL_A, 1'b1, 3'd1, 3'd0, 32'h7fffffff),
      make_item(ACT_SAMP, MSEL_A, 1'b1, 3'd7, 3'd0, 32'h66666666),
      make_item(2'd3, MSEL_L, 1'b1, 3'd7, 3'd7, 32'hffffffff),
      make_item(ACT_STEP, MSEL_A, VSEL_U, 3'd0, 3'd0, 32'h0),
      make_item(ACT_STEP, MSEL_L, 1'b1, 3'd7, 3'd7, 32'hffffffff)
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // First step after reset must give all zeros
    foreach (stim_table[k]) send_item(stim_table[k], k > 2);
    start <= 1'b0;
    wait (estimate_q.size() == 0);
    @(negedge clk);

    for (int n = 0; n < 290; n++) begin
      case ($urandom_range(0, 19))
        0: it = make_item(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom);
        1, 2, 3, 4, 5, 6, 7, 8:
          it = make_item(ACT_COEF, $urandom, $urandom,
                         ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3)),
                         ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3)),
                         rand_value());
        9, 10, 11, 12:
          it = make_item(ACT_SAMP, $urandom, $urandom,
                         ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(0, 1)),
                         $urandom, rand_value());
        default: it = make_item(ACT_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
      endcase
      // Clear matrix A now and then so values do not stay pinned at the rails
      if (n % 60 == 30) begin
        foreach (coef_a[k]) send_item(make_item(ACT_COEF, MSEL_A, VSEL_U, 3'(k / STATE_SIZE),
                                                3'(k % STATE_SIZE), 32'h0), 1'b0);
        start <= 1'b0;
        wait (estimate_q.size() == 0);
        @(negedge clk);
      end
      send_item(it, n % 50 < 40);
    end

    start <= 1'b0;
    wait (estimate_q.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && estimate_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/lso_pkg.sv
rtl/core/lso_front.sv
rtl/core/lso_back.sv
rtl/core/linear_state_observer_step.sv
tb/sv/tb.sv
